### design/tflru_pkg.sv
// Shared types and constants for the fully associative TLB with FIFO/LRU replacement.
// No dependencies; imported by the top level and by its checker.
`default_nettype none

package tflru_pkg;

  localparam int MAX_ENTRIES_DEF = 16;

  localparam int PAGE_W  = 32;
  localparam int FRAME_W = 32;
  localparam int STAMP_W = 32;

  // Configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_ADDR_W-1:0] REG_ENTRIES_IN_USE   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_REPLACEMENT_MODE = 2'd1;
  localparam logic [CFG_DATA_W-1:0] ENTRIES_IN_USE_RST   = 5'd16;

  localparam logic MODE_FIFO = 1'b0;
  localparam logic MODE_LRU  = 1'b1;

  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_INSERT = 1'b1;

  // Stream payloads
  localparam int IN_DATA_W  = PAGE_W + FRAME_W;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = FRAME_W + PAGE_W;
  localparam int OUT_USER_W = 2;

  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [FRAME_W-1:0] frame;
    logic [PAGE_W-1:0]  page;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

### design/tflru_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tflru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

### design/tlb_fifo_lru_replacement.sv
// Fully associative TLB, FIFO or LRU replacement, entries held in one RAM.
// Depends on tflru_pkg and tflru_ram.
//
// Use:
//   in_*  : one request per transfer. in_tuser[0] is the kind (0 lookup,
//           1 insert); in_tdata carries page and frame.
//   out_* : one result per request, in request order. out_tuser carries the
//           hit and evicted flags, out_tdata the frame found and the page
//           that was replaced.
//   cfg_* : write entries_in_use (index 0) or replacement_mode (index 1)
//           while no request is in flight.
// Operation: a request walks the held entries through the single RAM read
// port, one entry per cycle, then passes the drain and write-back states and
// writes the RAM at most once (not at all for a lookup or a FIFO hit).
// An empty TLB goes straight to write-back. The next request is taken in
// the cycle after the result is loaded, so no new request is taken while
// one is in flight.
// Reset empties the TLB (fill count and stamp counter cleared; the RAM
// needs no clearing pass) and restores the register defaults.
// A stalled receiver holds the result in the output register; one further
// request may be taken and worked up to its write-back meanwhile.
`default_nettype none

module tlb_fifo_lru_replacement #(
  parameter int MAX_ENTRIES = tflru_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // in_tdata: page [31:0], frame [63:32]
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [tflru_pkg::IN_DATA_W-1:0]   in_tdata,
  // in_tuser: req_type [0]
  input  wire logic [tflru_pkg::IN_USER_W-1:0]   in_tuser,
  // out_tdata: frame_out [31:0], evicted_page [63:32]
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic      [tflru_pkg::OUT_DATA_W-1:0]  out_tdata,
  // out_tuser: hit [0], evicted [1]
  output logic      [tflru_pkg::OUT_USER_W-1:0]  out_tuser,
  input  wire logic                              cfg_we,
  input  wire logic [tflru_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [tflru_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  import tflru_pkg::*;

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (CNT_W > CFG_DATA_W) ? CNT_W : CFG_DATA_W;
  localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_ENTRIES);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_WB    = 2'd3;

  logic [1:0]            state_r, state_nxt;
  logic [CFG_DATA_W-1:0] limit_cfg_r;
  logic                  mode_r;
  logic [CNT_W-1:0]      fill_r;
  logic [STAMP_W-1:0]    stamp_r;

  // Request being worked
  logic                  req_ins_r;
  logic [PAGE_W-1:0]     req_page_r;
  logic [FRAME_W-1:0]    req_frame_r;

  // Scan
  logic [CNT_W-1:0]      scan_cnt_r;
  logic                  rd_vld_r;
  logic [IDX_W-1:0]      rd_idx_r;
  logic                  found_r;
  logic [IDX_W-1:0]      match_idx_r;
  logic [FRAME_W-1:0]    match_frame_r;
  logic [IDX_W-1:0]      victim_idx_r;
  logic [STAMP_W-1:0]    victim_stamp_r;
  logic [PAGE_W-1:0]     victim_page_r;

  // Output register
  logic                  out_vld_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_USER_W-1:0] out_user_r;

  logic                  in_xfer;
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  entry_t                rd_entry;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  entry_t                wr_entry;
  logic                  wb_go;
  logic [CMP_W-1:0]      limit;
  logic                  has_room;
  logic                  do_append;
  logic                  do_evict;
  logic                  do_refresh;
  logic [STAMP_W-1:0]    stamp_new;

  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;

  assign rd_en   = (state_r == ST_SCAN);
  assign rd_addr = scan_cnt_r[IDX_W-1:0];

  // Writes happen only at write-back; the next scan starts later, so the
  // read port never sees a stale entry.
  tflru_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_entry),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_entry)
  );

  // Clamp the configured limit to 1..MAX_ENTRIES
  always_comb begin
    limit = CMP_W'(limit_cfg_r);
    if (limit_cfg_r == '0) begin
      limit = CMP_W'(1);
    end else if (limit > MAX_CMP) begin
      limit = MAX_CMP;
    end
  end

  assign has_room   = CMP_W'(fill_r) < limit;
  assign wb_go      = (state_r == ST_WB) && (!out_vld_r || out_tready);
  assign do_refresh = found_r && req_ins_r && (mode_r == MODE_LRU);
  assign do_append  = !found_r && req_ins_r && has_room;
  assign do_evict   = !found_r && req_ins_r && !has_room;
  assign stamp_new  = stamp_r + STAMP_W'(1);

  always_comb begin
    wr_en          = wb_go && (do_refresh || do_append || do_evict);
    wr_entry.page  = req_page_r;
    wr_entry.frame = req_frame_r;
    wr_entry.stamp = stamp_new;
    wr_addr        = victim_idx_r;
    if (do_refresh) begin
      wr_addr        = match_idx_r;
      wr_entry.frame = match_frame_r;
    end else if (do_append) begin
      wr_addr = fill_r[IDX_W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = (fill_r == '0) ? ST_WB : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_cnt_r + CNT_W'(1) == fill_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = ST_WB;
      ST_WB: begin
        if (wb_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      limit_cfg_r <= ENTRIES_IN_USE_RST;
      mode_r      <= MODE_FIFO;
      fill_r      <= '0;
      stamp_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= rd_en;
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_ENTRIES_IN_USE:   limit_cfg_r <= cfg_wdata;
          REG_REPLACEMENT_MODE: mode_r      <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (wr_en) begin
        stamp_r <= stamp_new;
      end
      if (wb_go && do_append) begin
        fill_r <= fill_r + CNT_W'(1);
      end
      if (wb_go) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Request, scan results and output payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_ins_r   <= in_tuser[0];
      req_page_r  <= in_tdata[PAGE_W-1:0];
      req_frame_r <= in_tdata[PAGE_W +: FRAME_W];
      scan_cnt_r  <= '0;
      found_r     <= 1'b0;
    end else if (rd_en) begin
      scan_cnt_r <= scan_cnt_r + CNT_W'(1);
    end
    if (rd_en) begin
      rd_idx_r <= rd_addr;
    end
    if (rd_vld_r) begin
      // Lowest matching index wins
      if (!found_r && (rd_entry.page == req_page_r)) begin
        found_r       <= 1'b1;
        match_idx_r   <= rd_idx_r;
        match_frame_r <= rd_entry.frame;
      end
      // Strictly smaller stamp: ties keep the lower index
      if ((rd_idx_r == '0) || (rd_entry.stamp < victim_stamp_r)) begin
        victim_idx_r   <= rd_idx_r;
        victim_stamp_r <= rd_entry.stamp;
        victim_page_r  <= rd_entry.page;
      end
    end
    if (wb_go) begin
      out_user_r <= {do_evict, found_r};
      out_data_r <= {(do_evict ? victim_page_r : {PAGE_W{1'b0}}),
                     (found_r ? match_frame_r : {FRAME_W{1'b0}})};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

`default_nettype wire

### design/tflru_chk.sv
// Port-level checker for tlb_fifo_lru_replacement, bound to the top level.
// Depends on tflru_pkg.
`default_nettype none

module tflru_chk (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_tvalid,
  input wire logic                              in_tready,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [tflru_pkg::OUT_DATA_W-1:0]  out_tdata,
  input wire logic [tflru_pkg::OUT_USER_W-1:0]  out_tuser
);

  import tflru_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // A page that was held is never replaced by the same request
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("hit and evicted both set");

  // Fields without meaning read as zero
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[0] || out_tdata[FRAME_W-1:0] == '0) &&
                   (out_tuser[1] || out_tdata[FRAME_W +: PAGE_W] == '0))
    else $error("unused result field not zero");

  // One request at a time: after a transfer the input is busy
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request taken while busy");

endmodule

bind tlb_fifo_lru_replacement tflru_chk u_tflru_chk (.*);

`default_nettype wire

### tb/tlb_fifo_lru_replacement_tb.sv
// Self-checking bench for the TLB with FIFO/LRU replacement: directed and random requests,
// each result checked against an in-bench translation predictor.
// Depends on tflru_pkg and the tlb_fifo_lru_replacement RTL.

module tlb_fifo_lru_replacement_tb;
  import tflru_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_3 = 2'd3;
  localparam int LONG_HOLD_CYCLES = 300;

  typedef struct packed {
    logic               kind;
    logic [PAGE_W-1:0]  page;
    logic [FRAME_W-1:0] frame;
  } tlb_req_t;

  typedef struct packed {
    logic               hit;
    logic [FRAME_W-1:0] frame_out;
    logic               evicted;
    logic [PAGE_W-1:0]  evicted_page;
  } tlb_resp_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [IN_USER_W-1:0]  in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  tlb_fifo_lru_replacement DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Predictor state
  logic [PAGE_W-1:0]     tlb_page  [MAX_ENTRIES_DEF];
  logic [FRAME_W-1:0]    tlb_frame [MAX_ENTRIES_DEF];
  logic [STAMP_W-1:0]    tlb_stamp [MAX_ENTRIES_DEF];
  int                    tlb_fill = 0;
  logic [STAMP_W-1:0]    tlb_stamp_ctr = '0;
  logic [CFG_DATA_W-1:0] tlb_limit_reg = ENTRIES_IN_USE_RST;
  logic                  tlb_mode = MODE_FIFO;

  tlb_req_t  pending_reqs[$];
  tlb_resp_t expected_resp[$];
  int        reqs_queued = 0;
  int        resps_checked = 0;
  int        mismatches = 0;
  int        in_idle_pct = 0;
  int        out_idle_pct = 0;
  int        long_hold_req = 0;

  logic      in_sent = 1'b0;
  logic      drv_valid;
  tlb_req_t  drv_req;
  int        hold_seen = 0;
  int        hold_left = 0;
  tlb_resp_t mon_want;

  function automatic tlb_resp_t predict_translation(tlb_req_t r);
    tlb_resp_t res;
    int        i;
    int        idx;
    int        lim;
    int        victim;
    res = '0;
    idx = -1;
    for (i = 0; i < tlb_fill; i++) begin
      if (idx < 0 && tlb_page[i] == r.page) idx = i;
    end
    lim = (tlb_limit_reg == 0) ? 1 :
          (int'(tlb_limit_reg) > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF : int'(tlb_limit_reg);
    if (idx >= 0) begin
      res.hit = 1'b1;
      res.frame_out = tlb_frame[idx];
      if (r.kind == REQ_INSERT && tlb_mode == MODE_LRU) begin
        tlb_stamp_ctr = tlb_stamp_ctr + STAMP_W'(1);
        tlb_stamp[idx] = tlb_stamp_ctr;
      end
    end else if (r.kind == REQ_INSERT) begin
      tlb_stamp_ctr = tlb_stamp_ctr + STAMP_W'(1);
      if (tlb_fill < lim) begin
        tlb_page[tlb_fill] = r.page;
        tlb_frame[tlb_fill] = r.frame;
        tlb_stamp[tlb_fill] = tlb_stamp_ctr;
        tlb_fill++;
      end else begin
        // oldest of all held entries, lowest index on a tie
        victim = 0;
        for (i = 1; i < tlb_fill; i++) begin
          if (tlb_stamp[i] < tlb_stamp[victim]) victim = i;
        end
        res.evicted = 1'b1;
        res.evicted_page = tlb_page[victim];
        tlb_page[victim] = r.page;
        tlb_frame[victim] = r.frame;
        tlb_stamp[victim] = tlb_stamp_ctr;
      end
    end
    return res;
  endfunction

  task automatic cmp_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Driver: hold the item until its transfer, then load the next one or idle
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      drv_valid = in_tvalid && !in_sent;
      if (!drv_valid && pending_reqs.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
        drv_req = pending_reqs.pop_front();
        in_tdata <= {drv_req.frame, drv_req.page};
        in_tuser <= drv_req.kind;
        drv_valid = 1'b1;
      end
      in_tvalid <= drv_valid;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (hold_seen != long_hold_req) begin
        hold_seen = long_hold_req;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  // Monitor: check results first, then predict for the accepted request
  always @(posedge clk) begin
    if (!rst_n) begin
      in_sent <= 1'b0;
    end else begin
      in_sent <= in_tvalid && in_tready;
      if (out_tvalid && out_tready) begin
        if (expected_resp.size() == 0) begin
          $display("%0t: result with nothing outstanding, expected none actual tuser=%b tdata=%h",
                   $time, out_tuser, out_tdata);
          mismatches++;
        end else begin
          mon_want = expected_resp.pop_front();
          cmp_field("hit", 32'(mon_want.hit), 32'(out_tuser[0]));
          cmp_field("frame_out", mon_want.frame_out, out_tdata[31:0]);
          cmp_field("evicted", 32'(mon_want.evicted), 32'(out_tuser[1]));
          cmp_field("evicted_page", mon_want.evicted_page, out_tdata[63:32]);
          resps_checked++;
        end
      end
      if (in_tvalid && in_tready)
        expected_resp.push_back(predict_translation({in_tuser[0], in_tdata[31:0],
                                                     in_tdata[63:32]}));
    end
  end

  task automatic queue_req(logic kind, logic [31:0] page, logic [31:0] frame);
    pending_reqs.push_back({kind, page, frame});
    reqs_queued++;
  endtask

  task automatic wait_drained();
    while (resps_checked != reqs_queued) @(negedge clk);
    repeat (24) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    if (idx == REG_ENTRIES_IN_USE) tlb_limit_reg = val;
    else if (idx == REG_REPLACEMENT_MODE) tlb_mode = val[0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random requests over a small page pool so that hits and refreshes are common
  task automatic random_reqs(int n);
    logic [31:0] pool [24];
    logic [31:0] pg;
    int          k;
    pool[0] = 32'h0000_0000;
    pool[1] = 32'hFFFF_FFFF;
    for (k = 2; k < 24; k++) pool[k] = $urandom();
    for (k = 0; k < n; k++) begin
      pg = ($urandom_range(3) != 0) ? pool[$urandom_range(23)] : $urandom();
      queue_req($urandom_range(1) ? REQ_INSERT : REQ_LOOKUP, pg, $urandom());
    end
  endtask

  task automatic random_phase(logic [CFG_DATA_W-1:0] limit, logic [CFG_DATA_W-1:0] mode_val,
                              int n);
    wait_drained();
    write_reg(REG_ENTRIES_IN_USE, limit);
    write_reg(REG_REPLACEMENT_MODE, mode_val);
    random_reqs(n);
  endtask

  initial begin
    #2_000_000;
    $display("tlb_fifo_lru_replacement: mismatch");
    $finish;
  end

  initial begin
    int k;
    in_idle_pct = 7;
    out_idle_pct = 58;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Register defaults: empty lookup, first append, hit
    queue_req(REQ_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    queue_req(REQ_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_req(REQ_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    wait_drained();

    // Limit of zero acts as one: every new page replaces the single entry
    write_reg(REG_ENTRIES_IN_USE, 5'd0);
    queue_req(REQ_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_req(REQ_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_req(REQ_INSERT, 32'hFFFF_FFFF, 32'h1234_5678);
    queue_req(REQ_LOOKUP, 32'hFFFF_FFFF, 32'hA5A5_A5A5);
    wait_drained();

    // LRU with three entries: re-insert refreshes, lookup does not
    write_reg(REG_ENTRIES_IN_USE, 5'd3);
    write_reg(REG_REPLACEMENT_MODE, 5'b11111);
    queue_req(REQ_INSERT, 32'h0000_0001, 32'h0000_0011);
    queue_req(REQ_INSERT, 32'h8000_0000, 32'h0000_0022);
    queue_req(REQ_INSERT, 32'hFFFF_FFFF, 32'h0000_0033);
    queue_req(REQ_LOOKUP, 32'h0000_0001, 32'h0000_0000);
    queue_req(REQ_INSERT, 32'h5555_5555, 32'hAAAA_AAAA);
    queue_req(REQ_INSERT, 32'hAAAA_AAAA, 32'h5555_5555);
    wait_drained();

    // Spare indexes are ignored; a limit above the maximum acts as the maximum
    write_reg(REG_SPARE_2, CFG_DATA_W'($urandom()));
    write_reg(REG_SPARE_3, CFG_DATA_W'($urandom()));
    write_reg(REG_ENTRIES_IN_USE, 5'd17);
    write_reg(REG_REPLACEMENT_MODE, 5'b11110);
    for (k = 0; k < 13; k++)
      queue_req(REQ_INSERT, 32'h0100_0000 + k, 32'hF0F0_0000 + k);

    random_phase(5'd16, {4'($urandom()), MODE_LRU}, 115);
    random_phase(5'd5, {4'($urandom()), MODE_FIFO}, 115);
    long_hold_req++;
    random_phase(5'd0, {4'($urandom()), MODE_LRU}, 115);

    in_idle_pct = 58;
    out_idle_pct = 7;
    random_phase(5'd31, {4'($urandom()), MODE_FIFO}, 115);
    random_phase(5'd1, {4'($urandom()), MODE_FIFO}, 115);
    random_phase(5'($urandom()), 5'($urandom()), 115);

    in_idle_pct = 0;
    out_idle_pct = 0;
    random_phase(5'd12, {4'($urandom()), MODE_LRU}, 115);
    random_phase(5'($urandom()), 5'($urandom()), 115);

    wait_drained();
    repeat (40) @(negedge clk);
    if (mismatches == 0 && expected_resp.size() == 0) begin
      $display("tlb_fifo_lru_replacement: match");
    end else begin
      $display("tlb_fifo_lru_replacement: mismatch");
    end
    $finish;
  end

endmodule

### files.f
design/tflru_pkg.sv
design/tflru_ram.sv
design/tlb_fifo_lru_replacement.sv
design/tflru_chk.sv
tb/tlb_fifo_lru_replacement_tb.sv
